### design/sgdm_pkg.sv
// Shared constants and types for the momentum update engine.
package sgdm_pkg;

    localparam int DATA_W     = 32;
    localparam int FRAC_BITS  = 16;
    localparam int IDX_W      = 12;
    localparam int HIST_DEPTH = 4096;
    localparam int ADDR_W     = $clog2(HIST_DEPTH);

    // Exact product, product after the Q16.16 shift, and one guard bit for the sums.
    localparam int PROD_W  = 2 * DATA_W;
    localparam int SHIFT_W = PROD_W - FRAC_BITS;
    localparam int SUM_W   = SHIFT_W + 1;

    // Stages between the history read and the write-back.
    localparam int NUM_STAGES = 3;

    // Result queue in front of the output port.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOMENTUM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY    = 2'd2;

    typedef struct packed {
        logic [NUM_STAGES-1:0]            valid;
        logic [NUM_STAGES-1:0][IDX_W-1:0] idx;
    } stage_tags_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } ram_wr_t;

    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] value;
        logic              sat;
    } result_t;

endpackage

### design/sgdm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module sgdm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/sgdm_datapath.sv
// Three-stage multiply, sum and saturate pipeline that produces the new history word.
module sgdm_datapath
    import sgdm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic [IDX_W-1:0]         in_idx,
    input  logic signed [DATA_W-1:0] in_grad,
    input  logic signed [DATA_W-1:0] in_weight,
    input  logic signed [DATA_W-1:0] rate,
    input  logic signed [DATA_W-1:0] momentum,
    input  logic signed [DATA_W-1:0] decay,
    input  logic [DATA_W-1:0]        old_hist,
    output stage_tags_t              tags,
    output ram_wr_t                  hist_wr,
    output result_t                  result
);

    // Clamp a wide sum to DATA_W bits; the top bit of the return value flags a clamp.
    function automatic logic [DATA_W:0] sat_sum(input logic [SUM_W-1:0] s);
        logic fits;
        logic [DATA_W-1:0] clamped;
        fits = (s[SUM_W-1:DATA_W-1] == {(SUM_W - DATA_W + 1){s[SUM_W-1]}});
        clamped = s[SUM_W-1] ? {1'b1, {(DATA_W - 1){1'b0}}} : {1'b0, {(DATA_W - 1){1'b1}}};
        return fits ? {1'b0, s[DATA_W-1:0]} : {1'b1, clamped};
    endfunction

    // Stage 1: operands, history word arrives from the RAM
    logic                     s1_valid_reg;
    logic [IDX_W-1:0]         s1_idx_reg;
    logic signed [DATA_W-1:0] s1_grad_reg;
    logic signed [DATA_W-1:0] s1_weight_reg;

    // Stage 2: shifted products
    logic                      s2_valid_reg;
    logic [IDX_W-1:0]          s2_idx_reg;
    logic signed [SHIFT_W-1:0] s2_rate_reg;
    logic signed [SHIFT_W-1:0] s2_mom_reg;
    logic signed [SHIFT_W-1:0] s2_decay_reg;

    // Stage 3: first saturated sum, decay term still pending
    logic                      s3_valid_reg;
    logic [IDX_W-1:0]          s3_idx_reg;
    logic [DATA_W-1:0]         s3_hist_reg;
    logic                      s3_flag_reg;
    logic signed [SHIFT_W-1:0] s3_decay_reg;

    logic signed [PROD_W-1:0] prod_rate_next;
    logic signed [PROD_W-1:0] prod_mom_next;
    logic signed [PROD_W-1:0] prod_decay_next;
    logic signed [DATA_W-1:0] old_signed;
    logic [SUM_W-1:0]         sum1_next;
    logic [SUM_W-1:0]         sum2_next;
    logic [DATA_W:0]          sat1_next;
    logic [DATA_W:0]          sat2_next;

    assign old_signed = $signed(old_hist);

    assign prod_rate_next  = PROD_W'(rate) * PROD_W'(s1_grad_reg);
    assign prod_mom_next   = PROD_W'(momentum) * PROD_W'(old_signed);
    assign prod_decay_next = PROD_W'(decay) * PROD_W'(s1_weight_reg);

    assign sum1_next = SUM_W'(s2_rate_reg) + SUM_W'(s2_mom_reg);
    assign sat1_next = sat_sum(sum1_next);

    assign sum2_next = SUM_W'($signed(s3_hist_reg)) + SUM_W'(s3_decay_reg);
    assign sat2_next = sat_sum(sum2_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_idx_reg    <= in_idx;
            s1_grad_reg   <= in_grad;
            s1_weight_reg <= in_weight;
        end
        s2_idx_reg   <= s1_idx_reg;
        s2_rate_reg  <= prod_rate_next[PROD_W-1:FRAC_BITS];
        s2_mom_reg   <= prod_mom_next[PROD_W-1:FRAC_BITS];
        s2_decay_reg <= prod_decay_next[PROD_W-1:FRAC_BITS];
        s3_idx_reg   <= s2_idx_reg;
        s3_hist_reg  <= sat1_next[DATA_W-1:0];
        s3_flag_reg  <= sat1_next[DATA_W];
        s3_decay_reg <= s2_decay_reg;
    end

    assign tags.valid  = {s3_valid_reg, s2_valid_reg, s1_valid_reg};
    assign tags.idx[0] = s1_idx_reg;
    assign tags.idx[1] = s2_idx_reg;
    assign tags.idx[2] = s3_idx_reg;

    assign hist_wr.en   = s3_valid_reg;
    assign hist_wr.addr = s3_idx_reg[ADDR_W-1:0];
    assign hist_wr.data = sat2_next[DATA_W-1:0];

    assign result.valid = s3_valid_reg;
    assign result.idx   = s3_idx_reg;
    assign result.value = sat2_next[DATA_W-1:0];
    assign result.sat   = s3_flag_reg | sat2_next[DATA_W];

endmodule

### design/sgd_momentum_update.sv
// Top level of the momentum update engine: config, history RAM, hazard check, result queue.
// Path: an accepted word passes datapath stages 1 to 3, then the result queue, to the output port.
// Throughput: one word per cycle while under eight words are outstanding; a word matching
//   one of the up to three words between history read and write-back waits for its write-back.
// Reset: configuration clears to zero, then a clearing pass writes zero to all 4096
//   history entries, one per cycle; in_ready stays low until the pass is done.
// The output queue holds eight words; input flows while output stalls, until eight are outstanding.
module sgd_momentum_update
    import sgdm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_write,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,

    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [IDX_W-1:0]         element_index,
    input  logic signed [DATA_W-1:0] gradient,
    input  logic signed [DATA_W-1:0] weight,

    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [IDX_W-1:0]         out_index,
    output logic signed [DATA_W-1:0] update_value,
    output logic                     saturated
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] rate_reg;
    logic signed [DATA_W-1:0] momentum_reg;
    logic signed [DATA_W-1:0] decay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg     <= '0;
            momentum_reg <= '0;
            decay_reg    <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_RATE:     rate_reg     <= $signed(cfg_data);
                CFG_MOMENTUM: momentum_reg <= $signed(cfg_data);
                CFG_DECAY:    decay_reg    <= $signed(cfg_data);
                default:      ; // drop writes beyond the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Clearing pass after reset: sweep the history RAM with zeros
    // ------------------------------------------------------------------
    logic              clear_done_reg;
    logic              clear_done_next;
    logic [ADDR_W-1:0] clear_addr_reg;
    logic [ADDR_W-1:0] clear_addr_next;

    always_comb
    begin
        clear_addr_next = clear_addr_reg;
        clear_done_next = clear_done_reg;
        if (!clear_done_reg)
        begin
            clear_addr_next = clear_addr_reg + 1'b1;
            if (clear_addr_reg == ADDR_W'(HIST_DEPTH - 1))
            begin
                clear_done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_done_reg <= 1'b0;
            clear_addr_reg <= '0;
        end
        else
        begin
            clear_done_reg <= clear_done_next;
            clear_addr_reg <= clear_addr_next;
        end
    end

    // ------------------------------------------------------------------
    // Input acceptance
    // Hold a word whose entry is still being read-modified-written by an
    // earlier word: its history read must see that word's write-back.
    // ------------------------------------------------------------------
    stage_tags_t          tags;
    logic                 hazard;
    logic                 in_accept;
    logic                 out_accept;
    logic [CNT_W-1:0]     outstanding_reg;
    logic [CNT_W-1:0]     outstanding_next;

    always_comb
    begin
        hazard = 1'b0;
        for (int s = 0; s < NUM_STAGES; s++)
        begin
            if (tags.valid[s] && (tags.idx[s] == element_index))
            begin
                hazard = 1'b1;
            end
        end
    end

    // Outstanding words never exceed the queue depth, so the queue cannot overflow.
    assign in_ready   = clear_done_reg && !hazard
                        && (outstanding_reg < CNT_W'(FIFO_DEPTH));
    assign in_accept  = in_valid && in_ready;
    assign out_accept = out_valid && out_ready;

    always_comb
    begin
        outstanding_next = outstanding_reg;
        case ({in_accept, out_accept})
            2'b10:   outstanding_next = outstanding_reg + 1'b1;
            2'b01:   outstanding_next = outstanding_reg - 1'b1;
            default: outstanding_next = outstanding_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    // ------------------------------------------------------------------
    // History RAM and update pipeline
    // ------------------------------------------------------------------
    ram_wr_t           hist_wr;
    result_t           result;
    logic [DATA_W-1:0] old_hist;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;

    // The clearing pass owns the write port until it finishes; no word is in flight then.
    assign ram_we    = clear_done_reg ? hist_wr.en   : 1'b1;
    assign ram_waddr = clear_done_reg ? hist_wr.addr : clear_addr_reg;
    assign ram_wdata = clear_done_reg ? hist_wr.data : '0;

    sgdm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_accept),
        .raddr (element_index[ADDR_W-1:0]),
        .rdata (old_hist)
    );

    sgdm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .in_idx    (element_index),
        .in_grad   (gradient),
        .in_weight (weight),
        .rate      (rate_reg),
        .momentum  (momentum_reg),
        .decay     (decay_reg),
        .old_hist  (old_hist),
        .tags      (tags),
        .hist_wr   (hist_wr),
        .result    (result)
    );

    // ------------------------------------------------------------------
    // Result queue: push every finished word, pop on output handshake
    // ------------------------------------------------------------------
    localparam int ENTRY_W = IDX_W + DATA_W + 1;

    logic [ENTRY_W-1:0] fifo_mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic [CNT_W-1:0]   fifo_cnt_reg;
    logic [CNT_W-1:0]   fifo_cnt_next;
    logic [ENTRY_W-1:0] head;

    always_comb
    begin
        wr_ptr_next   = result.valid ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next   = out_accept ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fifo_cnt_next = fifo_cnt_reg;
        case ({result.valid, out_accept})
            2'b10:   fifo_cnt_next = fifo_cnt_reg + 1'b1;
            2'b01:   fifo_cnt_next = fifo_cnt_reg - 1'b1;
            default: fifo_cnt_next = fifo_cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            fifo_cnt_reg <= fifo_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            fifo_mem_reg[wr_ptr_reg] <= {result.idx, result.value, result.sat};
        end
    end

    assign head         = fifo_mem_reg[rd_ptr_reg];
    assign out_valid    = (fifo_cnt_reg != '0);
    assign out_index    = head[ENTRY_W-1 -: IDX_W];
    assign update_value = $signed(head[DATA_W:1]);
    assign saturated    = head[0];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_accept_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_accept |-> clear_done_reg
    ) else $error("word accepted during history clearing pass");

    a_outstanding_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        outstanding_reg <= CNT_W'(FIFO_DEPTH)
    ) else $error("outstanding word count beyond queue depth");

    a_queue_within_outstanding: assert property (
        @(posedge clk) disable iff (!rst_n)
        fifo_cnt_reg <= outstanding_reg
    ) else $error("result queue holds more words than are outstanding");

    a_pipeline_within_outstanding: assert property (
        @(posedge clk) disable iff (!rst_n)
        (CNT_W'($countones(tags.valid)) + fifo_cnt_reg) == outstanding_reg
    ) else $error("in-flight and queued words disagree with outstanding count");

    a_write_follows_read: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_accept |-> ##3 hist_wr.en
    ) else $error("accepted word missed its history write-back");

endmodule

### dv/sgd_momentum_update_tb.sv
// Self-checking testbench for the momentum update engine: directed corners, then random blobs.
module sgd_momentum_update_tb;
    import sgdm_pkg::*;

    // One expected output word, as predicted at the moment its input word is accepted.
    typedef struct {
        logic [IDX_W-1:0]         index;
        logic signed [DATA_W-1:0] value;
        logic                     sat;
    } update_word_t;

    // Receiver behavior: always ready, or ready and stalled in runs of random length.
    typedef enum logic {SINK_OPEN, SINK_CHOPPY} sink_mode_t;

    // The port decodes two index bits; the fourth code names no register and must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic signed [DATA_W-1:0] Q_TOP    = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] Q_BOTTOM = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] Q_ONE    = 32'sh0001_0000;
    localparam logic signed [DATA_W-1:0] Q_HALF   = 32'sh0000_8000;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [DATA_W-1:0]        cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [IDX_W-1:0]         element_index = '0;
    logic signed [DATA_W-1:0] gradient = '0;
    logic signed [DATA_W-1:0] weight = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [IDX_W-1:0]         out_index;
    logic signed [DATA_W-1:0] update_value;
    logic                     saturated;

    // Shadow copies of the history memory and the three coefficients.
    logic signed [DATA_W-1:0] hist_model [HIST_DEPTH];
    logic signed [DATA_W-1:0] rate_q = '0;
    logic signed [DATA_W-1:0] momentum_q = '0;
    logic signed [DATA_W-1:0] decay_q = '0;

    // Updates still owed by the block, oldest first.
    update_word_t pending_updates[$];

    int errors = 0;
    int items_sent = 0;
    int updates_checked = 0;
    int clipped_seen = 0;
    int settings_loaded = 0;

    // Receiver control: the mode is set by the tests, a long hold is requested through
    // hold_request and then counted down by the receiver process itself.
    sink_mode_t sink_mode = SINK_OPEN;
    int         hold_request = 0;
    int         sink_hold = 0;
    int         sink_run = 0;
    logic       sink_stalled = 1'b0;

    sgd_momentum_update dut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Clamp a wide sum into signed Q16.16 and flag the clamp.
    function automatic logic signed [DATA_W-1:0] clip_q(input longint sum, inout logic hit);
        if (sum > longint'(Q_TOP))
        begin
            hit = 1'b1;
            return Q_TOP;
        end
        if (sum < longint'(Q_BOTTOM))
        begin
            hit = 1'b1;
            return Q_BOTTOM;
        end
        return sum[DATA_W-1:0];
    endfunction

    // Compute the new history value of one element and commit it to the shadow memory.
    // Each product of two 32-bit values is exact in 64 bits; the shift by the fraction
    // width floors toward minus infinity. The first sum clamps before the decay term
    // joins, and the second sum clamps again.
    function automatic update_word_t predict_update(input logic [IDX_W-1:0] idx,
                                                    input logic signed [DATA_W-1:0] grad,
                                                    input logic signed [DATA_W-1:0] wgt);
        update_word_t             word;
        logic                     hit;
        longint                   rate_term;
        longint                   momentum_term;
        longint                   decay_term;
        logic signed [DATA_W-1:0] first_sum;
        hit           = 1'b0;
        rate_term     = (longint'(rate_q) * longint'(grad)) >>> FRAC_BITS;
        momentum_term = (longint'(momentum_q) * longint'(hist_model[idx % HIST_DEPTH]))
                        >>> FRAC_BITS;
        decay_term    = (longint'(decay_q) * longint'(wgt)) >>> FRAC_BITS;
        first_sum     = clip_q(rate_term + momentum_term, hit);
        word.value    = clip_q(longint'(first_sum) + decay_term, hit);
        word.index    = idx;
        word.sat      = hit;
        hist_model[idx % HIST_DEPTH] = word.value;
        return word;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // Compare each word leaving the block with the oldest prediction, then predict
    // for a word entering at the same edge. Both sides are sampled at the edge, so
    // the values seen are the ones that made the handshake.
    always @(posedge clk)
    begin : watch_ports
        update_word_t head;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_updates.size() == 0)
                    report_mismatch("word with nothing owed, out_index", out_index, -1);
                else
                begin
                    head = pending_updates.pop_front();
                    if (out_index !== head.index)
                        report_mismatch("out_index", out_index, head.index);
                    if (update_value !== head.value)
                        report_mismatch("update_value", update_value, head.value);
                    if (saturated !== head.sat)
                        report_mismatch("saturated", saturated, head.sat);
                    updates_checked++;
                    if (head.sat)
                        clipped_seen++;
                end
            end
            if (in_valid && in_ready)
                pending_updates.insert(pending_updates.size(),
                                       predict_update(element_index, gradient, weight));
        end
    end

    // ------------------------------------------------------------------
    // Receiver
    // ------------------------------------------------------------------

    // Hold off for a requested number of cycles first; otherwise follow the mode.
    // In choppy mode alternate ready runs and stall runs of random length.
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            sink_hold    = hold_request;
            hold_request = 0;
        end
        if (sink_hold > 0)
        begin
            sink_hold--;
            out_ready <= 1'b0;
        end
        else if (sink_mode == SINK_OPEN)
            out_ready <= 1'b1;
        else
        begin
            if (sink_run == 0)
            begin
                sink_stalled = !sink_stalled;
                sink_run     = sink_stalled ? $urandom_range(1, 6) : $urandom_range(1, 12);
            end
            sink_run--;
            out_ready <= !sink_stalled;
        end
    end

    // ------------------------------------------------------------------
    // Sender and configuration
    // ------------------------------------------------------------------

    // Offer one word and return at the edge that accepts it. Leave valid high so that
    // a following word goes out back to back.
    task automatic send_word(input logic [IDX_W-1:0] idx,
                             input logic signed [DATA_W-1:0] grad,
                             input logic signed [DATA_W-1:0] wgt);
        in_valid      <= 1'b1;
        element_index <= idx;
        gradient      <= grad;
        weight        <= wgt;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    // Drop valid for the requested gap; with a gap of zero, valid is left as it is.
    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every owed update has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_updates.size() != 0);
    endtask

    // Write one register and mirror it; leave the write enable high for a following write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            CFG_RATE:     rate_q = value;
            CFG_MOMENTUM: momentum_q = value;
            CFG_DECAY:    decay_q = value;
            default:      ;
        endcase
    endtask

    // Load a full coefficient set for the next blob; call only while the block is idle.
    task automatic load_coeffs(input logic [DATA_W-1:0] rate,
                               input logic [DATA_W-1:0] momentum,
                               input logic [DATA_W-1:0] decay);
        write_reg(CFG_RATE, rate);
        write_reg(CFG_MOMENTUM, momentum);
        write_reg(CFG_DECAY, decay);
        cfg_write <= 1'b0;
        settings_loaded++;
    endtask

    // Gradient or weight: small values near zero half the time, else full-range values and extremes.
    function automatic logic signed [DATA_W-1:0] pick_operand();
        int span;
        span = $urandom_range(0, 1 << 19);
        case ($urandom_range(0, 9))
            0:       return Q_TOP;
            1:       return Q_BOTTOM;
            2, 3, 4: return $urandom;
            default: return span - (1 << 18);
        endcase
    endfunction

    // Coefficient: extremes, zero, full range, or a plausible value within +/-2.0.
    function automatic logic signed [DATA_W-1:0] pick_coeff();
        int span;
        span = $urandom_range(0, 1 << 18);
        case ($urandom_range(0, 7))
            0:       return Q_TOP;
            1:       return Q_BOTTOM;
            2:       return '0;
            3:       return $urandom;
            default: return span - (1 << 17);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Wait out the clearing pass, then run with the reset coefficients: every update is zero.
    task automatic test_reset_state();
        do
            @(posedge clk);
        while (!in_ready);
        send_word('0, Q_TOP, Q_BOTTOM);
        send_word(IDX_W'(HIST_DEPTH - 1), Q_BOTTOM, Q_TOP);
        wait_drained();
    endtask

    // Floor on negative products, a zero decay that ignores the weight, and the smallest
    // nonzero decay term.
    task automatic test_rounding_and_decay();
        load_coeffs(32'sd1, '0, '0);
        send_word(IDX_W'(1), -32'sd1, Q_TOP);
        send_word(IDX_W'(2), 32'sd1, Q_BOTTOM);
        send_word(IDX_W'(3), Q_ONE, '0);
        wait_drained();
        load_coeffs('0, '0, 32'sd1);
        send_word(IDX_W'(4), '0, -32'sd1);
        wait_drained();
    endtask

    // Clamp in each direction, in the first sum, in the second sum alone, and in both.
    task automatic test_saturation();
        load_coeffs(Q_TOP, '0, '0);
        send_word(IDX_W'(10), Q_TOP, '0);
        send_word(IDX_W'(11), Q_BOTTOM, '0);
        wait_drained();
        // Entry 11 now holds the most negative value; momentum at its most negative
        // squares it into a huge positive term.
        load_coeffs(Q_ONE, Q_BOTTOM, Q_TOP);
        send_word(IDX_W'(11), '0, Q_ONE);
        send_word(IDX_W'(12), Q_TOP, Q_ONE);
        send_word(IDX_W'(13), Q_BOTTOM, Q_BOTTOM);
        wait_drained();
    endtask

    // Hit the same entry while its previous update is still in flight: with unit rate
    // and momentum the history must accumulate across back-to-back words.
    task automatic test_back_to_back_hazard();
        load_coeffs(Q_ONE, Q_ONE, '0);
        repeat (4) send_word(IDX_W'(20), Q_ONE, '0);
        repeat (2)
        begin
            send_word(IDX_W'(21), Q_HALF, '0);
            send_word(IDX_W'(22), -Q_HALF, '0);
        end
        send_word(IDX_W'(20), -32'sd1, Q_TOP);
        wait_drained();
    endtask

    // Write the unused register code with all ones; nothing may change.
    task automatic test_unused_register();
        write_reg(CFG_UNUSED, '1);
        load_coeffs(32'sh0000_4000, 32'sh0000_C000, 32'sh0000_0040);
        send_word(IDX_W'(20), Q_TOP, Q_TOP);
        wait_drained();
    endtask

    // Hold the receiver off for a long stretch while offering words back to back, so the
    // result queue fills and the input stalls; then let it drain completely.
    task automatic test_output_backpressure();
        load_coeffs(Q_ONE, Q_HALF, 32'sh0000_0100);
        sink_mode    = SINK_OPEN;
        hold_request = 300;
        for (int i = 0; i < 40; i++)
            send_word(IDX_W'(i * 97), pick_operand(), pick_operand());
        wait_drained();
    endtask

    // Random blobs: each phase loads a coefficient set, then streams words in bursts.
    // Most words revisit a small pool of entries (including both ends of the memory) so
    // that histories build up and in-flight hazards are frequent.
    task automatic test_random_blobs();
        logic [IDX_W-1:0] pool [16];
        logic [IDX_W-1:0] idx;
        int               burst;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:       load_coeffs(32'sh0000_0290, 32'sh0000_E666, 32'sh0000_0001);
                1:       load_coeffs(Q_TOP, Q_TOP, Q_TOP);
                2:       load_coeffs(Q_BOTTOM, Q_BOTTOM, Q_BOTTOM);
                default: load_coeffs(pick_coeff(), pick_coeff(), pick_coeff());
            endcase
            sink_mode = (phase % 3 == 0) ? SINK_OPEN : SINK_CHOPPY;
            foreach (pool[i])
                pool[i] = IDX_W'($urandom_range(0, HIST_DEPTH - 1));
            pool[0]  = '0;
            pool[15] = IDX_W'(HIST_DEPTH - 1);
            idx      = pool[0];
            burst    = 0;
            repeat (120)
            begin
                if (burst == 0)
                begin
                    // Phases 1 and 5 skip the random pause between bursts.
                    if (phase % 4 != 1)
                        pause_sender($urandom_range(1, 10));
                    if ($urandom_range(0, 19) == 0)
                        wait_drained();
                    burst = $urandom_range(1, 40);
                end
                burst--;
                case ($urandom_range(0, 9))
                    0, 1:    ;  // reuse the previous entry, which may still be in flight
                    2, 3:    idx = IDX_W'($urandom_range(0, HIST_DEPTH - 1));
                    default: idx = pool[$urandom_range(0, 15)];
                endcase
                send_word(idx, pick_operand(), pick_operand());
            end
            wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        foreach (hist_model[i])
            hist_model[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_rounding_and_decay();
        test_saturation();
        test_back_to_back_hazard();
        test_unused_register();
        test_output_backpressure();
        test_random_blobs();

        // Drain, then keep watching for any stray word.
        wait_drained();
        repeat (NUM_STAGES + 8) @(posedge clk);

        $display("Run covered %0d words sent and %0d updates checked over %0d coefficient sets,",
                 items_sent, updates_checked, settings_loaded);
        $display("%0d of them clamped, with in-flight reuse and a full output queue exercised.",
                 clipped_seen);
        if (errors == 0 && pending_updates.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Stop a hung run.
    initial
    begin
        #4_000_000;
        $display("Timeout with %0d updates still owed.", pending_updates.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
